>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the window finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MDWF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define MDWF_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MDWF_ASSERT(label, clk, rst_n, prop, msg)
`define MDWF_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

>>> hw/rtl/mdwf_pkg.sv
// Package: shared constants and types of the max difference window finder.
`default_nettype none
package mdwf_pkg;

    localparam int unsigned     WINDOW_MAX_DEF  = 1024;
    localparam longint unsigned MAX_LENGTH_DEF  = 65535;

    localparam int unsigned     SUM_OUT_W       = 18;
    localparam int unsigned     START_OUT_W     = 16;
    localparam int unsigned     CFG_LEN_W       = 11;
    localparam int unsigned     PADDR_W         = 3;

    localparam logic [SUM_OUT_W-1:0]   SUM_LIMIT   = 18'h3FFFF;
    localparam logic [START_OUT_W-1:0] START_LIMIT = 16'hFFFF;

    // register index decoded from paddr[2]
    localparam logic               REG_WINDOW_LEN   = 1'b0;
    localparam logic [CFG_LEN_W-1:0] WINDOW_LEN_RESET = 11'd2;

    // per-item control bits carried down the pipeline
    typedef struct packed {
        logic last;   // final character of the string
        logic win;    // a full window ends on this character
        logic ovf;    // string has run past the maximum length
    } mdwf_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/mdwf_ring.sv
// Ring memory of recent neighbor differences, one write and one registered read.
`default_nettype none
module mdwf_ring
    import mdwf_pkg::*;
#(
    parameter int unsigned DEPTH  = WINDOW_MAX_DEF - 1,
    parameter int unsigned ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    logic [7:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write: a same-address read returns the old entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/mdwf_best.sv
// Best-window tracker: keeps the highest score and its start, forms the result.
`default_nettype none
module mdwf_best
    import mdwf_pkg::*;
#(
    parameter int unsigned ACC_W = 20
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire mdwf_ctl_t              ctl,
    input  wire logic [ACC_W-1:0]       sum,
    input  wire logic [START_OUT_W-1:0] start,
    output logic                        res_found,
    output logic [START_OUT_W-1:0]      res_start,
    output logic [SUM_OUT_W-1:0]        res_sum,
    output logic                        res_ovf
);

    logic                   found_reg, found_next;
    logic [ACC_W-1:0]       best_sum_reg, best_sum_next;
    logic [START_OUT_W-1:0] best_start_reg, best_start_next;
    logic                   take;

    // unsigned compare: a wrapped (negative) sum ranks above every positive one
    assign take = ctl.win && (!found_reg || (sum > best_sum_reg));

    always_comb
    begin
        found_next      = found_reg;
        best_sum_next   = best_sum_reg;
        best_start_next = best_start_reg;
        if (take)
        begin
            found_next      = 1'b1;
            best_sum_next   = sum;
            best_start_next = start;
        end
    end

    assign res_found = found_next;
    assign res_start = best_start_next;
    assign res_sum   = (best_sum_next > ACC_W'(SUM_LIMIT)) ? SUM_LIMIT
                                                          : best_sum_next[SUM_OUT_W-1:0];
    assign res_ovf   = ctl.ovf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            best_sum_reg   <= '0;
            best_start_reg <= '0;
        end
        else if (en)
        begin
            if (ctl.last)
            begin
                found_reg      <= 1'b0;
                best_sum_reg   <= '0;
                best_start_reg <= '0;
            end
            else
            begin
                found_reg      <= found_next;
                best_sum_reg   <= best_sum_next;
                best_start_reg <= best_start_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/max_difference_window_finder.sv
// Top level: sliding-window neighbor-difference scorer with APB window length.
//
//  channel   | dir | handshake               | contents
//  ----------+-----+-------------------------+----------------------------------
//  s_axis    | in  | tvalid/tready           | tdata[7:0] char, tlast end of string
//  m_axis    | out | tvalid/tready           | tdata start/sum, tuser found/ovf
//  apb       | in  | psel/penable/pready     | window_len at byte address 0
//
//  One character per cycle unless a result is blocked. Three stages: S0 takes the character,
//  writes its difference into the ring and issues the ring read of the
//  difference leaving the window; S1 updates the running sum from the read
//  data; S2 updates the best window and, on tlast, loads the output register.
//  The result passes through the S1, S2 and output registers after the last character.
//  Input stalls only while a finished result sits in S2 and the output
//  register is still full. Reset clears all control state; ring needs no clear.
`default_nettype none
`include "assert_macros.svh"
module max_difference_window_finder
    import mdwf_pkg::*;
#(
    parameter int unsigned     WINDOW_MAX = WINDOW_MAX_DEF,
    parameter longint unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // stream in
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] char_in
    input  wire logic               s_axis_tlast,   // is_last
    // stream out
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [39:0]             m_axis_tdata,   // [15:0] best_start, [33:16] best_sum
    output logic [1:0]              m_axis_tuser,   // [0] found, [1] overflow
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int unsigned     RING_DEPTH = WINDOW_MAX - 1;
    localparam int unsigned     PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned     WIN_W      = $clog2(WINDOW_MAX + 1);
    localparam longint unsigned CNT_LIMIT  = MAX_LENGTH + 1;
    localparam int unsigned     CNT_W      = $clog2(MAX_LENGTH + 2);
    localparam longint unsigned SUM_MAX    = longint'(RING_DEPTH) * 255;
    localparam int unsigned     SUM_RAW_W  = $clog2(SUM_MAX + 1);
    localparam int unsigned     SUM_W      = (SUM_RAW_W > SUM_OUT_W) ? SUM_RAW_W : SUM_OUT_W;
    // two extra bits: sum may drift below zero or past one window after a
    // mid-string length change; wrapped values still compare like the full word
    localparam int unsigned     ACC_W      = SUM_W + 2;

    // ---------------- configuration ----------------
    logic [CFG_LEN_W-1:0] window_len_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? 32'(window_len_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            window_len_reg <= pwdata[CFG_LEN_W-1:0];
        end
    end

    // effective window: 0 acts as 1, clamp at WINDOW_MAX
    logic [31:0]      wl32;
    logic [WIN_W-1:0] w_eff;

    always_comb
    begin
        wl32 = 32'(window_len_reg);
        if (wl32 == 32'd0)
        begin
            w_eff = WIN_W'(1);
        end
        else if (wl32 > 32'(WINDOW_MAX))
        begin
            w_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = wl32[WIN_W-1:0];
        end
    end

    // ---------------- pipeline control ----------------
    logic                 advance;
    logic                 s_acc;
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    mdwf_ctl_t            s1_ctl_reg;
    mdwf_ctl_t            s2_ctl_reg;
    logic                 m_valid_reg;

    assign advance       = !(s2_valid_reg && s2_ctl_reg.last && m_valid_reg && !m_axis_tready);
    assign s_axis_tready = advance;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // ---------------- S0: character intake ----------------
    logic [7:0]       prev_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [7:0]       c;
    logic [7:0]       diff;
    logic             do_diff;
    logic             do_sub;
    logic [WIN_W-1:0] back;
    logic [PTR_W:0]   ptr_x;
    logic [PTR_W:0]   back_x;
    logic [PTR_W:0]   idx_x;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] ptr_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic [63:0]      start64;
    logic [START_OUT_W-1:0] start_sat;
    mdwf_ctl_t        s0_ctl;

    always_comb
    begin
        c       = s_axis_tdata;
        diff    = (c >= prev_reg) ? (c - prev_reg) : (prev_reg - c);
        do_diff = (cnt_reg != '0) && (w_eff > WIN_W'(1));
        do_sub  = do_diff && (64'(cnt_reg) >= 64'(w_eff));
        back    = w_eff - WIN_W'(1);
        ptr_x   = {1'b0, ptr_reg};
        back_x  = (PTR_W+1)'(back);
        idx_x   = (ptr_x >= back_x) ? (ptr_x - back_x)
                                    : (ptr_x + (PTR_W+1)'(RING_DEPTH) - back_x);
        rd_addr = idx_x[PTR_W-1:0];
        ptr_inc = (ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : (ptr_reg + PTR_W'(1));
        cnt_inc = (64'(cnt_reg) < 64'(CNT_LIMIT)) ? (cnt_reg + CNT_W'(1)) : cnt_reg;
        start64 = 64'(cnt_inc) - 64'(w_eff) + 64'd1;
        start_sat = (start64 > 64'(START_LIMIT)) ? START_LIMIT : start64[START_OUT_W-1:0];
        s0_ctl.last = s_axis_tlast;
        s0_ctl.win  = 64'(cnt_inc) >= 64'(w_eff);
        s0_ctl.ovf  = 64'(cnt_inc) > 64'(MAX_LENGTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            ptr_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (s_acc)
        begin
            if (s_axis_tlast)
            begin
                prev_reg <= '0;
                ptr_reg  <= '0;
                cnt_reg  <= '0;
            end
            else
            begin
                prev_reg <= c;
                cnt_reg  <= cnt_inc;
                if (do_diff)
                begin
                    ptr_reg <= ptr_inc;
                end
            end
        end
    end

    logic [7:0] rd_data;

    mdwf_ring #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (s_acc && do_diff),
        .wr_addr (ptr_reg),
        .wr_data (diff),
        .rd_en   (s_acc),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------- S1: running sum ----------------
    logic [7:0]             s1_d_reg;
    logic                   s1_sub_reg;
    logic [START_OUT_W-1:0] s1_start_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       sum_new;

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_d_reg     <= do_diff ? diff : 8'd0;
            s1_sub_reg   <= do_sub;
            s1_ctl_reg   <= s0_ctl;
            s1_start_reg <= start_sat;
        end
    end

    assign sum_new = acc_reg - (s1_sub_reg ? ACC_W'(rd_data) : '0) + ACC_W'(s1_d_reg);

    logic [ACC_W-1:0]       s2_sum_reg;
    logic [START_OUT_W-1:0] s2_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s_acc;
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                acc_reg <= s1_ctl_reg.last ? '0 : sum_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            s2_sum_reg   <= sum_new;
            s2_start_reg <= s1_start_reg;
            s2_ctl_reg   <= s1_ctl_reg;
        end
    end

    // ---------------- S2: best window and result ----------------
    logic                   res_found;
    logic [START_OUT_W-1:0] res_start;
    logic [SUM_OUT_W-1:0]   res_sum;
    logic                   res_ovf;
    logic                   load_out;

    mdwf_best #(
        .ACC_W (ACC_W)
    ) u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance && s2_valid_reg),
        .ctl       (s2_ctl_reg),
        .sum       (s2_sum_reg),
        .start     (s2_start_reg),
        .res_found (res_found),
        .res_start (res_start),
        .res_sum   (res_sum),
        .res_ovf   (res_ovf)
    );

    assign load_out = advance && s2_valid_reg && s2_ctl_reg.last;

    logic [39:0] m_data_reg;
    logic [1:0]  m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= {6'd0, res_sum, res_start};
            m_user_reg <= {res_ovf, res_found};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // ---------------- checks ----------------
    `MDWF_ASSERT(a_stall_cause, clk, rst_n, !s_axis_tready |-> (s2_valid_reg && s2_ctl_reg.last && m_valid_reg), "input stalled without a blocked result")
    `MDWF_NEVER(a_ptr_range, clk, rst_n, 64'(ptr_reg) >= 64'(RING_DEPTH), "ring pointer out of range")
    `MDWF_NEVER(a_cnt_range, clk, rst_n, 64'(cnt_reg) > 64'(CNT_LIMIT), "character count past saturation")
    `MDWF_ASSERT(a_string_clear, clk, rst_n, (s_acc && s_axis_tlast) |=> (cnt_reg == '0 && ptr_reg == '0), "string state not cleared after last character")

endmodule
`default_nettype wire
